[hdl/cosine_taylor_partial_sum_macros.svh]
// Assertion macros for the RTL of the cosine partial-sum block.
// Each macro expects i_clk and i_rst_n to be visible in the module that uses it.
`ifndef COSINE_TAYLOR_PARTIAL_SUM_MACROS_SVH
`define COSINE_TAYLOR_PARTIAL_SUM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ctps_pkg.sv]
`timescale 1ns / 1ps

package ctps_pkg;

    localparam int ANGLE_W       = 32;
    localparam int TERM_IDX_W    = 5;
    localparam int FRAC_BITS     = 28;
    localparam int IFRAC         = 56;
    localparam int MAX_TERMS_DEF = 16;
    localparam int OP_W          = 64;
    localparam int HALF_W        = OP_W / 2;
    localparam int ACC_W         = IFRAC + OP_W;
    localparam int RED_W         = ANGLE_W + 1;
    localparam int RECIP_DEPTH   = 32;
    localparam int RECIP_W       = 56;
    localparam int RECIP_IW      = $clog2(RECIP_DEPTH);
    localparam int PC_W          = 5;

    // pi with 61 fraction bits, rounded half up to the angle format.
    localparam logic [63:0] PI_Q61    = 64'h6487ED5110B4611A;
    localparam logic [63:0] PI_F_U    = (PI_Q61 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS);
    localparam logic [63:0] TWO_PI_FU = (PI_Q61 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
    localparam logic signed [RED_W-1:0] PI_F     = RED_W'(PI_F_U);
    localparam logic signed [RED_W-1:0] TWO_PI_F = RED_W'(TWO_PI_FU);

    // Reciprocals 1/((2k-1)(2k)) with 56 fraction bits, rounded to nearest.
    localparam logic [RECIP_W:0] R_ONE = (RECIP_W + 1)'(1) << IFRAC;
    localparam logic [RECIP_W-1:0] RECIP_TABLE [RECIP_DEPTH] = '{
        RECIP_W'(0),
        RECIP_W'((R_ONE + 57'd1) / 57'd2),
        RECIP_W'((R_ONE + 57'd6) / 57'd12),
        RECIP_W'((R_ONE + 57'd15) / 57'd30),
        RECIP_W'((R_ONE + 57'd28) / 57'd56),
        RECIP_W'((R_ONE + 57'd45) / 57'd90),
        RECIP_W'((R_ONE + 57'd66) / 57'd132),
        RECIP_W'((R_ONE + 57'd91) / 57'd182),
        RECIP_W'((R_ONE + 57'd120) / 57'd240),
        RECIP_W'((R_ONE + 57'd153) / 57'd306),
        RECIP_W'((R_ONE + 57'd190) / 57'd380),
        RECIP_W'((R_ONE + 57'd231) / 57'd462),
        RECIP_W'((R_ONE + 57'd276) / 57'd552),
        RECIP_W'((R_ONE + 57'd325) / 57'd650),
        RECIP_W'((R_ONE + 57'd378) / 57'd756),
        RECIP_W'((R_ONE + 57'd435) / 57'd870),
        RECIP_W'((R_ONE + 57'd496) / 57'd992),
        RECIP_W'((R_ONE + 57'd561) / 57'd1122),
        RECIP_W'((R_ONE + 57'd630) / 57'd1260),
        RECIP_W'((R_ONE + 57'd703) / 57'd1406),
        RECIP_W'((R_ONE + 57'd780) / 57'd1560),
        RECIP_W'((R_ONE + 57'd861) / 57'd1722),
        RECIP_W'((R_ONE + 57'd946) / 57'd1892),
        RECIP_W'((R_ONE + 57'd1035) / 57'd2070),
        RECIP_W'((R_ONE + 57'd1128) / 57'd2256),
        RECIP_W'((R_ONE + 57'd1225) / 57'd2450),
        RECIP_W'((R_ONE + 57'd1326) / 57'd2652),
        RECIP_W'((R_ONE + 57'd1431) / 57'd2862),
        RECIP_W'((R_ONE + 57'd1540) / 57'd3080),
        RECIP_W'((R_ONE + 57'd1653) / 57'd3306),
        RECIP_W'((R_ONE + 57'd1770) / 57'd3540),
        RECIP_W'((R_ONE + 57'd1891) / 57'd3782)
    };

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic [TERM_IDX_W-1:0]     first_term;
        logic [TERM_IDX_W-1:0]     end_term;
    } t_in_word;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] partial_sum;
        logic                      saturated;
    } t_out_word;

    typedef enum logic [2:0] {
        RED_NONE,
        RED_MOD,
        RED_FOLD_HI,
        RED_FOLD_LO,
        RED_ABS
    } t_red_op;

    // Bit 1 picks the half of operand A, bit 0 the half of operand B.
    typedef enum logic [1:0] {
        PART_LL,
        PART_LH,
        PART_HL,
        PART_HH
    } t_part;

    typedef enum logic [1:0] {
        A_XA,
        A_TERM,
        A_PROD
    } t_asel;

    typedef enum logic [1:0] {
        B_XA,
        B_X2,
        B_RECIP
    } t_bsel;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD32,
        ACC_ADD64
    } t_acc_op;

    typedef enum logic [1:0] {
        DST_NONE,
        DST_X2,
        DST_PROD,
        DST_TERM
    } t_dst;

    typedef enum logic [1:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_EMPTY,
        COND_LAST
    } t_cond;

    typedef struct packed {
        t_red_op         red_op;
        logic            init;
        logic            mul_issue;
        t_part           part;
        t_asel           a_sel;
        t_bsel           b_sel;
        t_acc_op         acc_op;
        t_dst            dst;
        logic            sum_en;
        t_cond           cond;
        logic [PC_W-1:0] target;
        logic            fin;
    } t_uword;

    typedef struct packed {
        logic empty;
        logic last;
    } t_dp_status;

    // Program addresses.
    localparam logic [PC_W-1:0] S_RED_MOD = PC_W'(0);
    localparam logic [PC_W-1:0] S_FOLD_HI = PC_W'(1);
    localparam logic [PC_W-1:0] S_FOLD_LO = PC_W'(2);
    localparam logic [PC_W-1:0] S_ABS     = PC_W'(3);
    localparam logic [PC_W-1:0] S_SQ0     = PC_W'(4);
    localparam logic [PC_W-1:0] S_SQ1     = PC_W'(5);
    localparam logic [PC_W-1:0] S_SQ2     = PC_W'(6);
    localparam logic [PC_W-1:0] S_SQ3     = PC_W'(7);
    localparam logic [PC_W-1:0] S_SQ4     = PC_W'(8);
    localparam logic [PC_W-1:0] S_ADD     = PC_W'(9);
    localparam logic [PC_W-1:0] S_TX1     = PC_W'(10);
    localparam logic [PC_W-1:0] S_TX2     = PC_W'(11);
    localparam logic [PC_W-1:0] S_TX3     = PC_W'(12);
    localparam logic [PC_W-1:0] S_TX4     = PC_W'(13);
    localparam logic [PC_W-1:0] S_RC0     = PC_W'(14);
    localparam logic [PC_W-1:0] S_RC1     = PC_W'(15);
    localparam logic [PC_W-1:0] S_RC2     = PC_W'(16);
    localparam logic [PC_W-1:0] S_RC3     = PC_W'(17);
    localparam logic [PC_W-1:0] S_RC4     = PC_W'(18);
    localparam logic [PC_W-1:0] S_FIN     = PC_W'(19);

    // Control store. Each 64-bit product takes four partial products on the
    // shared multiplier; each is accumulated in the step after its issue.
    function automatic t_uword ucode_word(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '0;
        unique case (pc)
            S_RED_MOD: begin
                w.red_op = RED_MOD;
                w.cond   = COND_EMPTY;
                w.target = S_FIN;
            end
            S_FOLD_HI: begin
                w.red_op = RED_FOLD_HI;
            end
            S_FOLD_LO: begin
                w.red_op = RED_FOLD_LO;
            end
            S_ABS: begin
                w.red_op = RED_ABS;
                w.init   = 1'b1;
            end
            S_SQ0: begin
                w.mul_issue = 1'b1;
                w.part      = PART_LL;
                w.a_sel     = A_XA;
                w.b_sel     = B_XA;
            end
            S_SQ1: begin
                w.mul_issue = 1'b1;
                w.part      = PART_LH;
                w.a_sel     = A_XA;
                w.b_sel     = B_XA;
                w.acc_op    = ACC_LOAD;
            end
            S_SQ2: begin
                w.mul_issue = 1'b1;
                w.part      = PART_HL;
                w.a_sel     = A_XA;
                w.b_sel     = B_XA;
                w.acc_op    = ACC_ADD32;
            end
            S_SQ3: begin
                w.mul_issue = 1'b1;
                w.part      = PART_HH;
                w.a_sel     = A_XA;
                w.b_sel     = B_XA;
                w.acc_op    = ACC_ADD32;
            end
            S_SQ4: begin
                w.acc_op = ACC_ADD64;
                w.dst    = DST_X2;
            end
            S_ADD: begin
                w.sum_en    = 1'b1;
                w.mul_issue = 1'b1;
                w.part      = PART_LL;
                w.a_sel     = A_TERM;
                w.b_sel     = B_X2;
                w.cond      = COND_LAST;
                w.target    = S_FIN;
            end
            S_TX1: begin
                w.mul_issue = 1'b1;
                w.part      = PART_LH;
                w.a_sel     = A_TERM;
                w.b_sel     = B_X2;
                w.acc_op    = ACC_LOAD;
            end
            S_TX2: begin
                w.mul_issue = 1'b1;
                w.part      = PART_HL;
                w.a_sel     = A_TERM;
                w.b_sel     = B_X2;
                w.acc_op    = ACC_ADD32;
            end
            S_TX3: begin
                w.mul_issue = 1'b1;
                w.part      = PART_HH;
                w.a_sel     = A_TERM;
                w.b_sel     = B_X2;
                w.acc_op    = ACC_ADD32;
            end
            S_TX4: begin
                w.acc_op = ACC_ADD64;
                w.dst    = DST_PROD;
            end
            S_RC0: begin
                w.mul_issue = 1'b1;
                w.part      = PART_LL;
                w.a_sel     = A_PROD;
                w.b_sel     = B_RECIP;
            end
            S_RC1: begin
                w.mul_issue = 1'b1;
                w.part      = PART_LH;
                w.a_sel     = A_PROD;
                w.b_sel     = B_RECIP;
                w.acc_op    = ACC_LOAD;
            end
            S_RC2: begin
                w.mul_issue = 1'b1;
                w.part      = PART_HL;
                w.a_sel     = A_PROD;
                w.b_sel     = B_RECIP;
                w.acc_op    = ACC_ADD32;
            end
            S_RC3: begin
                w.mul_issue = 1'b1;
                w.part      = PART_HH;
                w.a_sel     = A_PROD;
                w.b_sel     = B_RECIP;
                w.acc_op    = ACC_ADD32;
            end
            S_RC4: begin
                w.acc_op = ACC_ADD64;
                w.dst    = DST_TERM;
                w.cond   = COND_ALWAYS;
                w.target = S_ADD;
            end
            S_FIN: begin
                w.fin = 1'b1;
            end
            default: begin
                w.fin = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

[hdl/cosine_taylor_partial_sum.sv]
// Partial cosine series over a range of terms.
// Input word: angle in radians (signed, 28 fraction bits) and the half-open
// term range [first_term, end_term); end_term is limited to MAX_TERMS.
// Output word: the signed sum of (-1)^k x^(2k)/(2k)! over the range, with
// the same fraction bits, and a flag set when it was clamped to 32 bits.
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. The input stalls while a word is being worked on.
// Each term needs two 64-bit products, and the one 32x32 multiplier builds
// each product from four partial products plus one accumulate step, driven
// by a microcoded sequencer. The next input word is taken the cycle after
// the result is loaded into the output register.
// A stalled output holds its word; the sequencer finishes the next word and
// then waits on its final step until the output register is free.
// Reset (synchronous, active low) empties the output and idles the sequencer.
`timescale 1ns / 1ps
`include "cosine_taylor_partial_sum_macros.svh"

module cosine_taylor_partial_sum
    import ctps_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);

    logic            r_busy;
    logic [PC_W-1:0] r_pc;
    logic            r_out_valid;
    t_out_word       r_out;

    t_uword     uw;
    t_uword     dp_uw;
    t_dp_status dp_status;
    t_out_word  dp_result;
    logic       in_accept;
    logic       slot_free;
    logic       take_jump;
    logic       res_load;
    logic       at_entry;

    assign o_in_stall  = r_busy;
    assign in_accept   = i_in_valid && !r_busy;
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign uw    = ucode_word(r_pc);
    assign dp_uw = r_busy ? uw : t_uword'('0);

    assign res_load = r_busy && uw.fin && slot_free;
    assign at_entry = r_busy && (r_pc == S_RED_MOD);

    always_comb begin
        unique case (uw.cond)
            COND_NEVER:  take_jump = 1'b0;
            COND_ALWAYS: take_jump = 1'b1;
            COND_EMPTY:  take_jump = dp_status.empty;
            COND_LAST:   take_jump = dp_status.last;
        endcase
    end

    ctps_datapath #(
        .MAX_TERMS(MAX_TERMS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_load  (in_accept),
        .i_in    (i_in_data),
        .i_uw    (dp_uw),
        .o_status(dp_status),
        .o_result(dp_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= S_RED_MOD;
            r_out_valid <= 1'b0;
        end else begin
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (in_accept) begin
                r_busy <= 1'b1;
                r_pc   <= S_RED_MOD;
            end else if (r_busy) begin
                if (uw.fin) begin
                    // Hold on the final step until the output word is free.
                    if (slot_free) begin
                        r_busy <= 1'b0;
                        r_out  <= dp_result;
                    end
                end else begin
                    r_pc <= take_jump ? uw.target : r_pc + PC_W'(1);
                end
            end
        end
    end

    `CTPS_ASSERT_NEXT(a_start, in_accept, at_entry, "start not at first step")
    `CTPS_ASSERT_NEXT(a_empty, at_entry && dp_status.empty, r_pc == S_FIN, "empty range did not skip")
    `CTPS_ASSERT_NEXT(a_finish, res_load, o_out_valid && !r_busy, "result not delivered")
    `CTPS_ASSERT_SAME(a_pc_range, r_busy, r_pc <= S_FIN, "step counter out of program")

endmodule

[hdl/ctps_datapath.sv]
`timescale 1ns / 1ps

module ctps_datapath
    import ctps_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF
) (
    input  logic       i_clk,
    input  logic       i_load,
    input  t_in_word   i_in,
    input  t_uword     i_uw,
    output t_dp_status o_status,
    output t_out_word  o_result
);

    localparam int KW        = $clog2(MAX_TERMS + 1);
    localparam int CW        = ((KW > TERM_IDX_W) ? KW : TERM_IDX_W) + 1;
    localparam int OUT_SHIFT = IFRAC - FRAC_BITS;
    localparam int SUM_XW    = OP_W + 1;

    localparam logic [OP_W-1:0]  TERM_ONE   = OP_W'(1) << IFRAC;
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (IFRAC - 1);
    localparam logic signed [SUM_XW-1:0] OUT_HALF = SUM_XW'(1) <<< (OUT_SHIFT - 1);
    localparam logic signed [SUM_XW-1:0] OUT_MAX  = SUM_XW'(2147483647);
    localparam logic signed [SUM_XW-1:0] OUT_MIN  = -(SUM_XW'(1) <<< (ANGLE_W - 1));

    logic signed [ANGLE_W-1:0] r_angle;
    logic [TERM_IDX_W-1:0]     r_first;
    logic [KW-1:0]             r_end;
    logic [KW-1:0]             r_k;
    logic signed [RED_W-1:0]   r_r;
    logic [OP_W-1:0]           r_xa;
    logic [OP_W-1:0]           r_x2;
    logic [OP_W-1:0]           r_prod;
    logic [OP_W-1:0]           r_term;
    logic [OP_W-1:0]           r_pp;
    logic [ACC_W-1:0]          r_acc;
    logic signed [OP_W-1:0]    r_sum;

    logic signed [RED_W-1:0] n_r;
    logic [ACC_W-1:0]        n_acc;
    logic signed [RED_W-1:0] angle_x;
    logic [RED_W-1:0]        r_mag;
    logic [KW-1:0]           end_clamped;
    logic [RECIP_IW-1:0]     recip_idx;
    logic [OP_W-1:0]         op_a;
    logic [OP_W-1:0]         op_b;
    logic [HALF_W-1:0]       a_half;
    logic [HALF_W-1:0]       b_half;
    logic [OP_W-1:0]         pp_next;
    logic [OP_W-1:0]         rounded;
    logic                    sum_on;
    logic signed [SUM_XW-1:0] sum_ext;
    logic signed [SUM_XW-1:0] sum_shr;

    assign end_clamped = (32'(i_in.end_term) > MAX_TERMS) ? KW'(MAX_TERMS) : KW'(i_in.end_term);

    assign o_status.empty = CW'(r_end) <= CW'(r_first);
    assign o_status.last  = (CW'(r_k) + CW'(1)) >= CW'(r_end);
    assign sum_on         = CW'(r_k) >= CW'(r_first);

    // With this angle format the truncated quotient by 2*pi is -1, 0 or 1,
    // so the remainder needs a compare with each bound and one correction.
    assign angle_x = RED_W'(r_angle);
    assign r_mag   = r_r[RED_W-1] ? RED_W'(-r_r) : RED_W'(r_r);

    always_comb begin
        n_r = r_r;
        unique case (i_uw.red_op)
            RED_MOD: begin
                if (angle_x >= TWO_PI_F) begin
                    n_r = angle_x - TWO_PI_F;
                end else if (angle_x <= -TWO_PI_F) begin
                    n_r = angle_x + TWO_PI_F;
                end else begin
                    n_r = angle_x;
                end
            end
            RED_FOLD_HI: begin
                if (r_r > PI_F) begin
                    n_r = r_r - TWO_PI_F;
                end
            end
            RED_FOLD_LO: begin
                if (r_r < -PI_F) begin
                    n_r = r_r + TWO_PI_F;
                end
            end
            RED_NONE, RED_ABS: begin
                n_r = r_r;
            end
            default: begin
                n_r = r_r;
            end
        endcase
    end

    assign recip_idx = RECIP_IW'(r_k);

    always_comb begin
        unique case (i_uw.a_sel)
            A_XA:    op_a = r_xa;
            A_TERM:  op_a = r_term;
            A_PROD:  op_a = r_prod;
            default: op_a = r_xa;
        endcase
        unique case (i_uw.b_sel)
            B_XA:    op_b = r_xa;
            B_X2:    op_b = r_x2;
            B_RECIP: op_b = OP_W'(RECIP_TABLE[recip_idx]);
            default: op_b = r_xa;
        endcase
    end

    assign a_half  = i_uw.part[1] ? op_a[OP_W-1:HALF_W] : op_a[HALF_W-1:0];
    assign b_half  = i_uw.part[0] ? op_b[OP_W-1:HALF_W] : op_b[HALF_W-1:0];
    assign pp_next = a_half * b_half;

    always_comb begin
        unique case (i_uw.acc_op)
            ACC_NONE:  n_acc = r_acc;
            ACC_LOAD:  n_acc = ACC_W'(r_pp) + ROUND_HALF;
            ACC_ADD32: n_acc = r_acc + (ACC_W'(r_pp) << HALF_W);
            ACC_ADD64: n_acc = r_acc + (ACC_W'(r_pp) << OP_W);
        endcase
    end

    // The rounding half was added at load, so the product is a plain slice.
    assign rounded = n_acc[ACC_W-1:IFRAC];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_angle <= i_in.angle;
            r_first <= i_in.first_term;
            r_end   <= end_clamped;
            r_sum   <= '0;
        end
        if (i_uw.red_op != RED_NONE) begin
            r_r <= n_r;
        end
        if (i_uw.red_op == RED_ABS) begin
            r_xa <= OP_W'(r_mag) << (IFRAC - FRAC_BITS);
        end
        if (i_uw.init) begin
            r_term <= TERM_ONE;
            r_k    <= '0;
        end
        if (i_uw.mul_issue) begin
            r_pp <= pp_next;
        end
        if (i_uw.acc_op != ACC_NONE) begin
            r_acc <= n_acc;
        end
        unique case (i_uw.dst)
            DST_NONE: begin
            end
            DST_X2: begin
                r_x2 <= rounded;
            end
            DST_PROD: begin
                r_prod <= rounded;
            end
            DST_TERM: begin
                r_term <= rounded;
            end
        endcase
        if (i_uw.sum_en) begin
            if (sum_on) begin
                r_sum <= r_k[0] ? r_sum - $signed(r_term) : r_sum + $signed(r_term);
            end
            r_k <= r_k + KW'(1);
        end
    end

    assign sum_ext = SUM_XW'(r_sum);
    assign sum_shr = (sum_ext + OUT_HALF) >>> OUT_SHIFT;

    always_comb begin
        if (sum_shr > OUT_MAX) begin
            o_result.partial_sum = OUT_MAX[ANGLE_W-1:0];
            o_result.saturated   = 1'b1;
        end else if (sum_shr < OUT_MIN) begin
            o_result.partial_sum = OUT_MIN[ANGLE_W-1:0];
            o_result.saturated   = 1'b1;
        end else begin
            o_result.partial_sum = sum_shr[ANGLE_W-1:0];
            o_result.saturated   = 1'b0;
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import ctps_pkg::t_in_word;
    import ctps_pkg::t_out_word;

    localparam int TERM_LIMIT = 16;
    localparam int ANG_FRAC   = 28;
    localparam int WORK_FRAC  = 56;
    localparam int RAND_WORDS = 600;
    localparam int TAIL_WAIT  = 200;

    localparam logic [63:0] PI_Q61_FX = 64'h6487ED5110B4611A;
    localparam longint PI_FX     = longint'((PI_Q61_FX + (64'd1 << 32)) >> 33);
    localparam longint TWO_PI_FX = longint'((PI_Q61_FX + (64'd1 << 31)) >> 32);

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_data;

    // Shared by both sides: when set, neither side inserts idle cycles.
    bit no_idle;

    class cos_series_board;
        t_out_word   sums_due[$];
        int unsigned n_errors = 0;

        // (a * b) >> 56, rounded half up, on unsigned Q8.56 magnitudes.
        function logic [63:0] mul_q56(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            p = p + (128'd1 << (WORK_FRAC - 1));
            return p[WORK_FRAC+63:WORK_FRAC];
        endfunction

        // 1/((2k-1)(2k)) with 56 fraction bits, rounded to nearest.
        function logic [63:0] inv_fact_step(int unsigned k);
            logic [63:0] d;
            d = 64'(2 * k - 1) * 64'(2 * k);
            return ((64'd1 << WORK_FRAC) + d / 64'd2) / d;
        endfunction

        function t_out_word predict_cos_sum(t_in_word w);
            t_out_word   res_word;
            longint      ang;
            longint      r;
            longint      sum;
            longint      res;
            logic [63:0] xa;
            logic [63:0] x2;
            logic [63:0] term;
            logic [63:0] biased;
            int unsigned first_idx;
            int unsigned stop_idx;
            res_word  = '0;
            first_idx = 32'(w.first_term);
            stop_idx  = 32'(w.end_term);
            if (stop_idx > TERM_LIMIT) begin
                stop_idx = TERM_LIMIT;
            end
            if (stop_idx <= first_idx) begin
                return res_word;
            end
            ang = longint'($signed(w.angle));
            r   = ang % TWO_PI_FX;
            if (r > PI_FX) begin
                r = r - TWO_PI_FX;
            end
            if (r < -PI_FX) begin
                r = r + TWO_PI_FX;
            end
            if (r < 0) begin
                r = -r;
            end
            xa   = 64'(r) << (WORK_FRAC - ANG_FRAC);
            x2   = mul_q56(xa, xa);
            term = 64'd1 << WORK_FRAC;
            sum  = 0;
            for (int unsigned k = 0; k < stop_idx; k++) begin
                if (k > 0) begin
                    term = mul_q56(mul_q56(term, x2), inv_fact_step(k));
                end
                if (k >= first_idx) begin
                    if (k[0]) begin
                        sum = sum - longint'(term);
                    end else begin
                        sum = sum + longint'(term);
                    end
                end
            end
            // Round half up while dropping to the angle format, via an offset
            // that keeps the shift on a non-negative value.
            biased = 64'(sum) + (64'd1 << 63) + (64'd1 << (WORK_FRAC - ANG_FRAC - 1));
            res    = longint'(biased >> (WORK_FRAC - ANG_FRAC))
                   - (longint'(1) << (63 - (WORK_FRAC - ANG_FRAC)));
            if (res > longint'(32'sh7FFF_FFFF)) begin
                res                = longint'(32'sh7FFF_FFFF);
                res_word.saturated = 1'b1;
            end else if (res < -longint'(64'h8000_0000)) begin
                res                = -longint'(64'h8000_0000);
                res_word.saturated = 1'b1;
            end
            res_word.partial_sum = res[31:0];
            return res_word;
        endfunction

        function void note_input(t_in_word w);
            sums_due.push_back(predict_cos_sum(w));
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (sums_due.size() == 0) begin
                n_errors++;
                $display("%0t ns: result with none expected, got sum %0d sat %0b",
                         $time, $signed(got.partial_sum), got.saturated);
                return;
            end
            want = sums_due.pop_front();
            if (got.partial_sum !== want.partial_sum) begin
                n_errors++;
                $display("%0t ns: partial_sum expected %0d, got %0d", $time,
                         $signed(want.partial_sum), $signed(got.partial_sum));
            end
            if (got.saturated !== want.saturated) begin
                n_errors++;
                $display("%0t ns: saturated expected %0b, got %0b", $time,
                         want.saturated, got.saturated);
            end
        endfunction

        function int unsigned outstanding();
            return sums_due.size();
        endfunction
    endclass

    cos_series_board board;

    cosine_taylor_partial_sum u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic int unsigned pick_gap();
        return no_idle ? 0 : $urandom_range(0, 12);
    endfunction

    task automatic send_word(input t_in_word w);
        int unsigned gap;
        t_in_word    junk;
        gap = pick_gap();
        repeat (gap) begin
            junk.angle      = $urandom;
            junk.first_term = 5'($urandom_range(0, 31));
            junk.end_term   = 5'($urandom_range(0, 31));
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            i_in_data  <= junk;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_input(w);
    endtask

    task automatic send_angle(input longint ang, input int unsigned first_idx,
                              input int unsigned stop_idx);
        t_in_word w;
        w.angle      = ang[31:0];
        w.first_term = first_idx[4:0];
        w.end_term   = stop_idx[4:0];
        send_word(w);
    endtask

    // The last word must not stay valid while the block drains.
    task automatic wait_results_done();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    // Angles near the folding points of the range reduction, small ones,
    // ones over [-pi, pi], the extremes and random ones for the modulo.
    function automatic longint rand_angle();
        longint a;
        case ($urandom_range(0, 5))
            0: a = longint'($signed($urandom));
            1: a = longint'($urandom_range(0, 32'(2 * PI_FX))) - PI_FX;
            2: a = PI_FX + longint'($urandom_range(0, 8)) - 4;
            3: a = TWO_PI_FX + longint'($urandom_range(0, 16)) - 8;
            4: a = longint'($urandom_range(0, 65535)) - 32768;
            default: a = $urandom_range(0, 1) ? 64'sh7FFF_FFFF : -64'sh8000_0000;
        endcase
        if ((a > 64'sh7FFF_FFFF || a < -64'sh8000_0000) || $urandom_range(0, 1)) begin
            a = -a;
        end
        return a;
    endfunction

    initial begin
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            int unsigned gap;
            gap = pick_gap();
            repeat (gap) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            board.check_result(o_out_data);
        end
    end

    initial begin
        int unsigned first_idx;
        int unsigned stop_idx;
        board      = new();
        no_idle    = 1'b0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Extremes of the angle, both folds, empty ranges and clamped ends.
        send_angle(0, 0, 16);
        send_angle(0, 0, 1);
        send_angle(64'sh7FFF_FFFF, 0, 16);
        send_angle(-64'sh8000_0000, 0, 16);
        send_angle(PI_FX, 0, 16);
        send_angle(-PI_FX, 0, 16);
        send_angle(PI_FX + 1, 0, 16);
        send_angle(-PI_FX - 1, 0, 16);
        send_angle(TWO_PI_FX, 0, 16);
        send_angle(-TWO_PI_FX, 1, 2);
        send_angle(PI_FX, 1, 2);
        send_angle(PI_FX, 2, 3);
        send_angle(PI_FX, 15, 16);
        send_angle(64'sh1234_5678, 0, 0);
        send_angle(PI_FX, 7, 3);
        send_angle(PI_FX, 0, 31);
        send_angle(PI_FX, 16, 31);
        send_angle(PI_FX, 31, 31);
        send_angle(PI_FX, 31, 0);
        send_angle(PI_FX / 2, 3, 31);
        send_angle(TWO_PI_FX - 1, 1, 16);
        send_angle(-1, 0, 16);
        send_angle(1, 15, 16);

        // Let the block drain completely before the random traffic.
        wait_results_done();

        for (int i = 0; i < RAND_WORDS; i++) begin
            if (i % 50 == 0) begin
                no_idle = ($urandom_range(0, 2) == 0);
            end
            if (i == RAND_WORDS / 2) begin
                wait_results_done();
            end
            if ($urandom_range(0, 9) < 7) begin
                stop_idx  = $urandom_range(1, TERM_LIMIT);
                first_idx = $urandom_range(0, stop_idx - 1);
            end else begin
                first_idx = $urandom_range(0, 31);
                stop_idx  = $urandom_range(0, 31);
            end
            send_angle(rand_angle(), first_idx, stop_idx);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        wait_results_done();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (board.n_errors == 0) begin
            $display("[cosine_taylor_partial_sum] OK");
        end else begin
            $display("[cosine_taylor_partial_sum] ERROR");
        end
        $finish;
    end

    initial begin
        #(15_000_000);
        $display("%0t ns: timeout", $time);
        $display("[cosine_taylor_partial_sum] ERROR");
        $finish;
    end

endmodule
